@@ hw/rtl/ewpe_pkg.sv @@
// ============================================================================
// ewpe_pkg: shared definitions for the edge window pedestal estimator
// Register map, method codes, reset values, parameter defaults and the
// handshake status type shared by the iterative arithmetic units.
// ============================================================================
package ewpe_pkg;

    // Parameter defaults.
    localparam int MAX_WINDOW_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port geometry.
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int REG_INDEX_W = 2;
    localparam int METHOD_W    = 2;
    localparam int COUNT_REG_W = 5;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_INDEX_W-1:0] REG_METHOD     = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_HEAD_COUNT = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_TAIL_COUNT = 2'd2;

    // Window selection codes.
    localparam logic [METHOD_W-1:0] METHOD_HEAD = 2'd0;
    localparam logic [METHOD_W-1:0] METHOD_TAIL = 2'd1;
    localparam logic [METHOD_W-1:0] METHOD_BOTH = 2'd2;

    // Register reset values.
    localparam logic [METHOD_W-1:0]    METHOD_RESET     = METHOD_HEAD;
    localparam logic [COUNT_REG_W-1:0] HEAD_COUNT_RESET = 5'd3;
    localparam logic [COUNT_REG_W-1:0] TAIL_COUNT_RESET = 5'd5;

    // Output fields are unsigned 12.4 fixed point.
    localparam int              OUT_W   = 16;
    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ hw/rtl/ewpe_fifo.sv @@
// ============================================================================
// ewpe_fifo: small request queue between front and back
// Holds finished waveform summaries until the back end is free to take them.
// ============================================================================
module ewpe_fifo
    import ewpe_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    // Storage needs no reset: an entry is only read after it was written.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/ewpe_div.sv @@
// ============================================================================
// ewpe_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module ewpe_div
    import ewpe_pkg::*;
#(
    parameter int W  = 20,
    parameter int DW = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic [W-1:0]  quotient,
    output unit_stat_t    stat
);

    localparam int CNTW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]  acc_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, acc_reg[W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W);
                acc_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                acc_reg <= {acc_reg[W-2:0], fits};
                rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/ewpe_sqrt.sv @@
// ============================================================================
// ewpe_sqrt: iterative integer square root
// Digit-by-digit method, one root bit per cycle.
// ============================================================================
module ewpe_sqrt
    import ewpe_pkg::*;
#(
    parameter int XW = 40
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [XW-1:0]   radicand,
    output logic [XW/2-1:0] root,
    output unit_stat_t      stat
);

    localparam int RW   = XW / 2;
    localparam int CNTW = $clog2(RW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [XW-1:0] x_reg;
    logic [RW-1:0] root_reg;
    logic [RW+1:0] rem_reg;

    logic [RW+3:0] rem_shift;
    logic [RW+3:0] trial;
    logic          fits;
    logic [RW+3:0] diff;

    // Bring down the next two radicand bits and test root*4+1.
    always_comb
    begin
        rem_shift = {rem_reg, x_reg[XW-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
        diff      = rem_shift - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(RW);
                x_reg    <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                x_reg    <= {x_reg[XW-3:0], 2'b00};
                root_reg <= {root_reg[RW-2:0], fits};
                rem_reg  <= fits ? diff[RW+1:0] : rem_shift[RW+1:0];
                cnt_reg  <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/ewpe_front.sv @@
// ============================================================================
// ewpe_front: per-sample accumulation
// Takes one sample per cycle while the queue has room, keeps the head sums
// and a line of running totals from which the tail window sums fall out,
// and on the last sample queues a summary of the waveform for the back end.
// ============================================================================
module ewpe_front
    import ewpe_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CW      = $clog2(MAX_WINDOW + 1),
    localparam int SUMW    = SAMPLE_BITS + CW,
    localparam int SQW     = 2 * SAMPLE_BITS + CW,
    localparam int ENTRY_W = METHOD_W + 2 * CW + 1 + 2 * SUMW + 2 * SQW
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    input  logic [METHOD_W-1:0]    method,
    input  logic [COUNT_REG_W-1:0] head_count,
    input  logic [COUNT_REG_W-1:0] tail_count,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [ENTRY_W-1:0]     q_data
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SB = SAMPLE_BITS;

    // A count of zero acts as one; a count above the window limit is clipped.
    function automatic logic [CW-1:0] eff_count(input logic [COUNT_REG_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0)
        begin
            r = CW'(1);
        end
        else if (int'(v) > MAX_WINDOW)
        begin
            r = CW'(MAX_WINDOW);
        end
        else
        begin
            r = CW'(v);
        end
        return r;
    endfunction

    logic [CW-1:0]   idx_reg;
    logic [SUMW-1:0] hsum_reg;
    logic [SQW-1:0]  hsq_reg;
    logic [SUMW-1:0] csum_reg [MAX_WINDOW];
    logic [SQW-1:0]  csq_reg  [MAX_WINDOW];

    logic               accept;
    logic [2*SB-1:0]    sq;
    logic [CW-1:0]      hc;
    logic [CW-1:0]      tc;
    logic [METHOD_W-1:0] m;
    logic               in_head;
    logic [CW-1:0]      len;
    logic [SUMW-1:0]    hsum_next;
    logic [SQW-1:0]     hsq_next;
    logic [SUMW-1:0]    csum_next;
    logic [SQW-1:0]     csq_next;
    logic [IW-1:0]      tail_idx;
    logic [SUMW-1:0]    tsum;
    logic [SQW-1:0]     tsq;
    logic               short_wf;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && last;

    // Sample classification and the sums it feeds.
    always_comb
    begin
        sq  = {{SB{1'b0}}, sample} * {{SB{1'b0}}, sample};
        hc  = eff_count(head_count);
        tc  = eff_count(tail_count);
        m   = (method == METHOD_BOTH || method == METHOD_TAIL || method == METHOD_HEAD)
              ? method : METHOD_BOTH;
        in_head = (idx_reg < hc);
        len = (idx_reg == CW'(MAX_WINDOW)) ? idx_reg : idx_reg + CW'(1);

        hsum_next = in_head ? hsum_reg + SUMW'(sample) : hsum_reg;
        hsq_next  = in_head ? hsq_reg + SQW'(sq) : hsq_reg;

        // Running totals wrap; the tail sum is the difference across tc samples.
        csum_next = csum_reg[0] + SUMW'(sample);
        csq_next  = csq_reg[0] + SQW'(sq);
        tail_idx  = IW'(tc - CW'(1));
        tsum      = csum_next - csum_reg[tail_idx];
        tsq       = csq_next - csq_reg[tail_idx];

        short_wf = ((m != METHOD_TAIL) && (len < hc)) || ((m != METHOD_HEAD) && (len < tc));

        q_data = {m, hc, tc, short_wf, hsum_next, hsq_next, tsum, tsq};
    end

    // Per-sample state; the head sums and index restart after the last sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            hsum_reg <= '0;
            hsq_reg  <= '0;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                csum_reg[i] <= '0;
                csq_reg[i]  <= '0;
            end
        end
        else if (accept)
        begin
            idx_reg  <= last ? '0 : len;
            hsum_reg <= last ? '0 : hsum_next;
            hsq_reg  <= last ? '0 : hsq_next;
            csum_reg[0] <= csum_next;
            csq_reg[0]  <= csq_next;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                csum_reg[i] <= csum_reg[i-1];
                csq_reg[i]  <= csq_reg[i-1];
            end
        end
    end

endmodule

@@ hw/rtl/ewpe_back.sv @@
// ============================================================================
// ewpe_back: per-waveform statistics
// Takes one waveform summary from the queue, works out mean and sigma of the
// needed windows with a shared divider and a square root unit, picks the
// window and holds the result in the output register (zeros if too short).
// ============================================================================
module ewpe_back
    import ewpe_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CW      = $clog2(MAX_WINDOW + 1),
    localparam int SUMW    = SAMPLE_BITS + CW,
    localparam int SQW     = 2 * SAMPLE_BITS + CW,
    localparam int ENTRY_W = METHOD_W + 2 * CW + 1 + 2 * SUMW + 2 * SQW
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENTRY_W-1:0] q_data,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   base_mean,
    output logic [OUT_W-1:0]   base_sigma,
    output logic               used_tail,
    output logic               too_short
);

    localparam int PRODW = 2 * SUMW;
    localparam int RADW  = PRODW + 8;
    localparam int ROOTW = RADW / 2;
    localparam int DIVW  = (ROOTW > OUT_W) ? ROOTW : OUT_W;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MEAN,
        B_MEAN_WAIT,
        B_SQR,
        B_NSQ,
        B_ROOT,
        B_ROOT_WAIT,
        B_SIG,
        B_SIG_WAIT,
        B_OUT
    } back_state_t;

    // Truncated result saturates at the top of the 12.4 range.
    function automatic logic [OUT_W-1:0] sat16(input logic [DIVW-1:0] q);
        logic [OUT_W-1:0] r;
        if (q > DIVW'(OUT_MAX))
        begin
            r = OUT_MAX;
        end
        else
        begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

    // Unpacked queue entry.
    logic [METHOD_W-1:0] q_method;
    logic [CW-1:0]       q_hc;
    logic [CW-1:0]       q_tc;
    logic                q_short;
    logic [SUMW-1:0]     q_hsum;
    logic [SQW-1:0]      q_hsq;
    logic [SUMW-1:0]     q_tsum;
    logic [SQW-1:0]      q_tsq;

    assign {q_method, q_hc, q_tc, q_short, q_hsum, q_hsq, q_tsum, q_tsq} = q_data;

    back_state_t         state_reg, state_next;
    logic [METHOD_W-1:0] e_method_reg, e_method_next;
    logic [CW-1:0]       e_hc_reg, e_hc_next;
    logic [CW-1:0]       e_tc_reg, e_tc_next;
    logic                e_short_reg, e_short_next;
    logic [SUMW-1:0]     e_hsum_reg, e_hsum_next;
    logic [SQW-1:0]      e_hsq_reg, e_hsq_next;
    logic [SUMW-1:0]     e_tsum_reg, e_tsum_next;
    logic [SQW-1:0]      e_tsq_reg, e_tsq_next;
    logic                win_tail_reg, win_tail_next;
    logic [PRODW-1:0]    prod_reg, prod_next;
    logic [RADW-1:0]     rad_reg, rad_next;
    logic [OUT_W-1:0]    mean_reg, mean_next;
    logic [OUT_W-1:0]    h_mean_reg, h_mean_next;
    logic [OUT_W-1:0]    h_sig_reg, h_sig_next;
    logic [OUT_W-1:0]    t_mean_reg, t_mean_next;
    logic [OUT_W-1:0]    t_sig_reg, t_sig_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_mean_reg, out_mean_next;
    logic [OUT_W-1:0]    out_sig_reg, out_sig_next;
    logic                out_tail_reg, out_tail_next;
    logic                out_short_reg, out_short_next;

    logic [SUMW-1:0]  cur_sum;
    logic [SQW-1:0]   cur_sq;
    logic [CW-1:0]    cur_n;
    logic [PRODW-1:0] n_sq;
    logic [PRODW-1:0] diff;
    logic             div_start;
    logic [DIVW-1:0]  div_dividend;
    logic [DIVW-1:0]  div_quot;
    unit_stat_t       div_stat;
    logic             sqrt_start;
    logic [ROOTW-1:0] sqrt_root;
    unit_stat_t       sqrt_stat;
    logic             tail_sel;
    logic [OUT_W-1:0] sig_now;

    // Window under work.
    always_comb
    begin
        cur_sum = win_tail_reg ? e_tsum_reg : e_hsum_reg;
        cur_sq  = win_tail_reg ? e_tsq_reg : e_hsq_reg;
        cur_n   = win_tail_reg ? e_tc_reg : e_hc_reg;
        n_sq    = {{SQW{1'b0}}, cur_n} * {{CW{1'b0}}, cur_sq};
        diff    = (n_sq > prod_reg) ? n_sq - prod_reg : '0;
    end

    // Shared divider: mean first, then sigma.
    assign div_start    = (state_reg == B_MEAN) || (state_reg == B_SIG);
    assign div_dividend = (state_reg == B_MEAN) ? DIVW'({cur_sum, 4'b0000}) : DIVW'(sqrt_root);
    assign sqrt_start   = (state_reg == B_ROOT);

    ewpe_div #(
        .W  (DIVW),
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cur_n),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    ewpe_sqrt #(
        .XW (RADW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rad_reg),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        e_method_next  = e_method_reg;
        e_hc_next      = e_hc_reg;
        e_tc_next      = e_tc_reg;
        e_short_next   = e_short_reg;
        e_hsum_next    = e_hsum_reg;
        e_hsq_next     = e_hsq_reg;
        e_tsum_next    = e_tsum_reg;
        e_tsq_next     = e_tsq_reg;
        win_tail_next  = win_tail_reg;
        prod_next      = prod_reg;
        rad_next       = rad_reg;
        mean_next      = mean_reg;
        h_mean_next    = h_mean_reg;
        h_sig_next     = h_sig_reg;
        t_mean_next    = t_mean_reg;
        t_sig_next     = t_sig_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_mean_next  = out_mean_reg;
        out_sig_next   = out_sig_reg;
        out_tail_next  = out_tail_reg;
        out_short_next = out_short_reg;
        q_pop          = 1'b0;
        sig_now        = sat16(div_quot);

        tail_sel = !e_short_reg && ((e_method_reg == METHOD_TAIL) ||
                   ((e_method_reg == METHOD_BOTH) && (t_sig_reg < h_sig_reg)));

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    e_method_next = q_method;
                    e_hc_next     = q_hc;
                    e_tc_next     = q_tc;
                    e_short_next  = q_short;
                    e_hsum_next   = q_hsum;
                    e_hsq_next    = q_hsq;
                    e_tsum_next   = q_tsum;
                    e_tsq_next    = q_tsq;
                    win_tail_next = (q_method == METHOD_TAIL);
                    state_next    = q_short ? B_OUT : B_MEAN;
                end
            end
            B_MEAN:
            begin
                state_next = B_MEAN_WAIT;
            end
            B_MEAN_WAIT:
            begin
                if (div_stat.done)
                begin
                    mean_next  = sat16(div_quot);
                    state_next = B_SQR;
                end
            end
            B_SQR:
            begin
                prod_next  = {{SUMW{1'b0}}, cur_sum} * {{SUMW{1'b0}}, cur_sum};
                state_next = B_NSQ;
            end
            B_NSQ:
            begin
                rad_next   = {diff, 8'h00};
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                state_next = B_ROOT_WAIT;
            end
            B_ROOT_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = B_SIG;
                end
            end
            B_SIG:
            begin
                state_next = B_SIG_WAIT;
            end
            B_SIG_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (win_tail_reg)
                    begin
                        t_mean_next = mean_reg;
                        t_sig_next  = sig_now;
                        state_next  = B_OUT;
                    end
                    else
                    begin
                        h_mean_next = mean_reg;
                        h_sig_next  = sig_now;
                        if (e_method_reg == METHOD_BOTH)
                        begin
                            win_tail_next = 1'b1;
                            state_next    = B_MEAN;
                        end
                        else
                        begin
                            state_next = B_OUT;
                        end
                    end
                end
            end
            B_OUT:
            begin
                // Result goes out once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_short_next = e_short_reg;
                    out_tail_next  = tail_sel;
                    if (e_short_reg)
                    begin
                        out_mean_next = '0;
                        out_sig_next  = '0;
                    end
                    else if (tail_sel)
                    begin
                        out_mean_next = t_mean_reg;
                        out_sig_next  = t_sig_reg;
                    end
                    else
                    begin
                        out_mean_next = h_mean_reg;
                        out_sig_next  = h_sig_reg;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            e_method_reg  <= METHOD_HEAD;
            e_hc_reg      <= '0;
            e_tc_reg      <= '0;
            e_short_reg   <= 1'b0;
            e_hsum_reg    <= '0;
            e_hsq_reg     <= '0;
            e_tsum_reg    <= '0;
            e_tsq_reg     <= '0;
            win_tail_reg  <= 1'b0;
            prod_reg      <= '0;
            rad_reg       <= '0;
            mean_reg      <= '0;
            h_mean_reg    <= '0;
            h_sig_reg     <= '0;
            t_mean_reg    <= '0;
            t_sig_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_mean_reg  <= '0;
            out_sig_reg   <= '0;
            out_tail_reg  <= 1'b0;
            out_short_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            e_method_reg  <= e_method_next;
            e_hc_reg      <= e_hc_next;
            e_tc_reg      <= e_tc_next;
            e_short_reg   <= e_short_next;
            e_hsum_reg    <= e_hsum_next;
            e_hsq_reg     <= e_hsq_next;
            e_tsum_reg    <= e_tsum_next;
            e_tsq_reg     <= e_tsq_next;
            win_tail_reg  <= win_tail_next;
            prod_reg      <= prod_next;
            rad_reg       <= rad_next;
            mean_reg      <= mean_next;
            h_mean_reg    <= h_mean_next;
            h_sig_reg     <= h_sig_next;
            t_mean_reg    <= t_mean_next;
            t_sig_reg     <= t_sig_next;
            out_valid_reg <= out_valid_next;
            out_mean_reg  <= out_mean_next;
            out_sig_reg   <= out_sig_next;
            out_tail_reg  <= out_tail_next;
            out_short_reg <= out_short_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign base_mean  = out_mean_reg;
    assign base_sigma = out_sig_reg;
    assign used_tail  = out_tail_reg;
    assign too_short  = out_short_reg;

endmodule

@@ hw/rtl/edge_window_pedestal_estimator_core.sv @@
// ============================================================================
// edge_window_pedestal_estimator_core: baseline mean and RMS from waveform edges
// Top level: configuration registers, front end, summary queue, back end.
// ============================================================================
// The block takes one ADC sample per clock cycle while the input is ready
// and gives one result per waveform, whose end is the sample marked last.
// The front end takes a sample in every cycle while the two-entry summary
// queue has room. The back end works on one waveform at a time with the
// shared one-bit-per-cycle divider (mean, then sigma) and the
// one-bit-per-cycle square root unit, for each window that is needed;
// a waveform too short for its window skips the arithmetic. While the back
// end works, the front end goes on taking samples of the next waveforms;
// the input stalls once the queue is full. Registers sit at byte addresses
// 0 (method), 4 (head_count) and 8 (tail_count).
module edge_window_pedestal_estimator_core
    import ewpe_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       base_mean,
    output logic [OUT_W-1:0]       base_sigma,
    output logic                   used_tail,
    output logic                   too_short
);

    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int SUMW    = SAMPLE_BITS + CW;
    localparam int SQW     = 2 * SAMPLE_BITS + CW;
    localparam int ENTRY_W = METHOD_W + 2 * CW + 1 + 2 * SUMW + 2 * SQW;

    logic [METHOD_W-1:0]    method_reg;
    logic [COUNT_REG_W-1:0] head_count_reg;
    logic [COUNT_REG_W-1:0] tail_count_reg;

    logic [REG_INDEX_W-1:0] reg_index;
    logic                   cfg_write;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    logic [ENTRY_W-1:0]     q_wdata;
    logic [ENTRY_W-1:0]     q_rdata;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg     <= METHOD_RESET;
            head_count_reg <= HEAD_COUNT_RESET;
            tail_count_reg <= TAIL_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_METHOD:     method_reg     <= pwdata[METHOD_W-1:0];
                REG_HEAD_COUNT: head_count_reg <= pwdata[COUNT_REG_W-1:0];
                REG_TAIL_COUNT: tail_count_reg <= pwdata[COUNT_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            REG_METHOD:     prdata = DATA_W'(method_reg);
            REG_HEAD_COUNT: prdata = DATA_W'(head_count_reg);
            REG_TAIL_COUNT: prdata = DATA_W'(tail_count_reg);
            default:        prdata = '0;
        endcase
    end

    ewpe_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .last       (last),
        .method     (method_reg),
        .head_count (head_count_reg),
        .tail_count (tail_count_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    ewpe_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    ewpe_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_rdata),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .base_mean  (base_mean),
        .base_sigma (base_sigma),
        .used_tail  (used_tail),
        .too_short  (too_short)
    );

endmodule
